// File: hdl/crtl_pkg.sv
// Shared types and constants for the code range table lookup.
// Holds the packed table entry layout and register index codes.
// No dependencies.
`default_nettype none

package crtl_pkg;

	// Width of the index table entry count field.
	localparam int TBL_COUNT_W = 29;

	// Bytes per index entry, as a shift amount.
	localparam int ENTRY_SHIFT = 3;

	// Configuration register index width and codes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_END   = 2'd1;

	// Request kinds carried by req_type.
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// One stored range entry.
	typedef struct packed {
		logic [31:0]            range_start;
		logic [31:0]            range_end;
		logic [31:0]            tbl_addr;
		logic [TBL_COUNT_W-1:0] tbl_count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: hdl/crtl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the range table storage; no dependencies.
`default_nettype none

module crtl_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/code_range_table_lookup.sv
// Code range table lookup: an add item goes through the add and done states to the output register.
// A lookup reads one stored entry per cycle through the table RAM read port until a hit
// or the end of the filled entries.
// One item is in work at a time, so the next item is taken once the last result has entered the output register.
// Reset (arst_n, asynchronous, active low) empties the table and clears the
// default table registers; table contents are not cleared.
`default_nettype none

module code_range_table_lookup
	import crtl_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]            cfg_data,
	// Input item channel.
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   req_type,
	input  wire logic                   is_loadable,
	input  wire logic                   is_executable,
	input  wire logic [31:0]            seg_vaddr,
	input  wire logic [31:0]            base_addr,
	input  wire logic [31:0]            mem_size,
	input  wire logic [31:0]            index_addr,
	input  wire logic [31:0]            index_bytes,
	input  wire logic                   last_header,
	input  wire logic [31:0]            pc,
	// Result item channel.
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [31:0]                 table_addr,
	output logic [TBL_COUNT_W-1:0]      entry_count,
	output logic                        matched,
	output logic                        recorded,
	output logic                        table_full
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADD  = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0] def_start_q;
	logic [31:0] def_end_q;

	// Captured item payload.
	logic                   req_q;
	logic                   qual_q;
	logic [31:0]            start_q;
	logic [31:0]            size_q;
	logic [31:0]            iaddr_q;
	logic [TBL_COUNT_W-1:0] count_q;
	logic [31:0]            pc_q;

	// Table bookkeeping and scan pointers.
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             rd_pend_s1;

	// Finished result waiting for the output register.
	logic [31:0]            res_addr_q;
	logic [TBL_COUNT_W-1:0] res_count_q;
	logic                   res_matched_q;
	logic                   res_recorded_q;
	logic                   res_full_q;

	// Output register.
	logic                   out_valid_q;
	logic [31:0]            out_addr_q;
	logic [TBL_COUNT_W-1:0] out_count_q;
	logic                   out_matched_q;
	logic                   out_recorded_q;
	logic                   out_full_q;

	// RAM signals.
	logic             ram_we;
	entry_t           ram_wdata;
	entry_t           rd_entry;
	logic [31:0]      def_diff;
	logic             in_take;
	logic             tbl_full;
	logic             rd_hit;
	logic             scan_more;
	logic             out_load;

	crtl_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[IDX_W-1:0]),
		.wdata (ram_wdata),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	// Handshake and decode.
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign tbl_full  = (fill_q >= DEPTH_C);
	assign ram_we    = (state_q == S_ADD) && qual_q && !tbl_full;
	assign rd_hit    = rd_pend_s1 && (rd_entry.range_start <= pc_q)
		&& (pc_q < rd_entry.range_end);
	assign scan_more = (scan_idx_q < fill_q);
	assign def_diff  = def_end_q - def_start_q;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// New entry: the end address is formed here from the registered start.
	always_comb begin
		ram_wdata.range_start = start_q;
		ram_wdata.range_end   = start_q + size_q;
		ram_wdata.tbl_addr    = iaddr_q;
		ram_wdata.tbl_count   = count_q;
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_start_q <= '0;
			def_end_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEF_START: def_start_q <= cfg_data;
				REG_DEF_END:   def_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the item payload at accept.
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q   <= req_type;
			qual_q  <= (index_addr != '0) && is_loadable && is_executable;
			start_q <= base_addr + seg_vaddr;
			size_q  <= mem_size;
			iaddr_q <= index_addr;
			count_q <= index_bytes[31:ENTRY_SHIFT];
			pc_q    <= pc;
		end
	end

	// Sequencer: add writes one entry, lookup streams reads and compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					scan_idx_q <= '0;
					rd_pend_s1 <= 1'b0;
					if (in_take) begin
						state_q <= (req_type == REQ_ADD) ? S_ADD : S_SCAN;
					end
				end
				S_ADD: begin
					if (ram_we) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (rd_hit || (!rd_pend_s1 && !scan_more)) begin
						rd_pend_s1 <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						rd_pend_s1 <= scan_more;
						if (scan_more) begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result formation for both item kinds.
	always_ff @(posedge clk) begin
		if (state_q == S_ADD) begin
			res_addr_q     <= '0;
			res_count_q    <= '0;
			res_matched_q  <= 1'b0;
			res_recorded_q <= qual_q && !tbl_full;
			res_full_q     <= qual_q && tbl_full;
		end else if (state_q == S_SCAN) begin
			res_recorded_q <= 1'b0;
			res_full_q     <= 1'b0;
			if (rd_hit) begin
				res_addr_q    <= rd_entry.tbl_addr;
				res_count_q   <= rd_entry.tbl_count;
				res_matched_q <= 1'b1;
			end else begin
				res_addr_q    <= def_start_q;
				res_count_q   <= def_diff[31:ENTRY_SHIFT];
				res_matched_q <= 1'b0;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q     <= res_addr_q;
			out_count_q    <= res_count_q;
			out_matched_q  <= res_matched_q;
			out_recorded_q <= res_recorded_q;
			out_full_q     <= res_full_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign table_addr  = out_addr_q;
	assign entry_count = out_count_q;
	assign matched     = out_matched_q;
	assign recorded    = out_recorded_q;
	assign table_full  = out_full_q;

`ifndef ASSERT_OFF
	// The fill count never runs past the table depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count exceeds table depth");

	// The fill count grows by at most one per cycle and never shrinks.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count moved by more than one");

	// The scan pointer never passes the filled part of the table.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_idx_q <= fill_q))
		else $error("scan pointer beyond filled entries");

	// A read is only outstanding while a lookup scans.
	a_pend_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == S_SCAN))
		else $error("table read outstanding outside a scan");

	// A result never reports both a lookup hit and an add.
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_matched_q && (out_recorded_q || out_full_q)))
		else $error("result mixes lookup and add fields");
`endif

endmodule

`default_nettype wire

// File: tb/code_range_table_lookup_checker.sv
`timescale 1ns / 100ps
// Checker for the code range table lookup: watches the config, request and result channels.
// Keeps its own copy of the range table and compares every result with its prediction.
// Depends on crtl_pkg for widths, register indexes and request kinds.

module code_range_table_lookup_checker
	import crtl_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   req_type,
	input  logic                   is_loadable,
	input  logic                   is_executable,
	input  logic [31:0]            seg_vaddr,
	input  logic [31:0]            base_addr,
	input  logic [31:0]            mem_size,
	input  logic [31:0]            index_addr,
	input  logic [31:0]            index_bytes,
	input  logic [31:0]            pc,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [31:0]            table_addr,
	input  logic [TBL_COUNT_W-1:0] entry_count,
	input  logic                   matched,
	input  logic                   recorded,
	input  logic                   table_full,
	output int                     mismatches,
	output int                     outstanding
);

	typedef struct packed {
		logic [31:0]            table_addr;
		logic [TBL_COUNT_W-1:0] entry_count;
		logic                   matched;
		logic                   recorded;
		logic                   table_full;
	} table_response_t;

	// Shadow copy of the range table and the fallback table registers.
	logic [31:0]            span_lo    [TABLE_DEPTH];
	logic [31:0]            span_hi    [TABLE_DEPTH];
	logic [31:0]            unwind_addr[TABLE_DEPTH];
	logic [TBL_COUNT_W-1:0] unwind_cnt [TABLE_DEPTH];
	int unsigned            spans_filled;
	logic [31:0]            fallback_start;
	logic [31:0]            fallback_end;

	table_response_t expected_responses[$];

	// Applies one request to the shadow table and returns the response it should produce.
	function automatic table_response_t serve_request(logic kind, logic ld, logic ex,
		logic [31:0] vaddr, logic [31:0] base, logic [31:0] size, logic [31:0] iaddr,
		logic [31:0] ibytes, logic [31:0] lookup_pc);
		table_response_t resp;
		logic [31:0]     seg_start;
		logic [31:0]     fallback_span;
		bit              hit;
		int              i;
		resp = '0;
		hit = 1'b0;
		if (kind == REQ_ADD) begin
			if (iaddr != 0 && ld && ex) begin
				if (spans_filled >= TABLE_DEPTH) begin
					resp.table_full = 1'b1;
				end else begin
					// Both ends wrap modulo 2^32.
					seg_start = base + vaddr;
					span_lo[spans_filled] = seg_start;
					span_hi[spans_filled] = seg_start + size;
					unwind_addr[spans_filled] = iaddr;
					unwind_cnt[spans_filled] = ibytes[31:ENTRY_SHIFT];
					spans_filled++;
					resp.recorded = 1'b1;
				end
			end
		end else begin
			// The first stored range holding the pc wins.
			for (i = 0; i < spans_filled && !hit; i++) begin
				if (span_lo[i] <= lookup_pc && lookup_pc < span_hi[i]) begin
					resp.table_addr = unwind_addr[i];
					resp.entry_count = unwind_cnt[i];
					resp.matched = 1'b1;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				fallback_span = fallback_end - fallback_start;
				resp.table_addr = fallback_start;
				resp.entry_count = fallback_span[31:ENTRY_SHIFT];
			end
		end
		return resp;
	endfunction

	// Prints one mismatch and counts it.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Track configuration writes, predict on request accept, compare on result accept.
	always @(posedge clk or negedge arst_n) begin : track
		table_response_t want;
		if (!arst_n) begin
			spans_filled = 0;
			fallback_start = '0;
			fallback_end = '0;
			expected_responses.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEF_START: fallback_start = cfg_data;
					REG_DEF_END:   fallback_end = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_responses.push_back(serve_request(req_type, is_loadable,
					is_executable, seg_vaddr, base_addr, mem_size, index_addr,
					index_bytes, pc));
			end
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("result with no request outstanding", table_addr, '0);
				end else begin
					want = expected_responses.pop_front();
					if (table_addr !== want.table_addr)
						report_mismatch("table_addr", table_addr, want.table_addr);
					if (entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(entry_count),
							32'(want.entry_count));
					if (matched !== want.matched)
						report_mismatch("matched", 32'(matched), 32'(want.matched));
					if (recorded !== want.recorded)
						report_mismatch("recorded", 32'(recorded), 32'(want.recorded));
					if (table_full !== want.table_full)
						report_mismatch("table_full", 32'(table_full),
							32'(want.table_full));
				end
			end
		end
		outstanding = expected_responses.size();
	end

endmodule

// File: tb/code_range_table_lookup_tb.sv
`timescale 1ns / 100ps
// Top of the code range table lookup testbench: clock, reset, stimulus and verdict.
// Depends on crtl_pkg, the code_range_table_lookup block and its checker.

module code_range_table_lookup_tb;
	import crtl_pkg::*;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 600;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [31:0]            cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   req_type = REQ_ADD;
	logic                   is_loadable = 1'b0;
	logic                   is_executable = 1'b0;
	logic [31:0]            seg_vaddr = '0;
	logic [31:0]            base_addr = '0;
	logic [31:0]            mem_size = '0;
	logic [31:0]            index_addr = '0;
	logic [31:0]            index_bytes = '0;
	logic                   last_header = 1'b0;
	logic [31:0]            pc = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [31:0]            table_addr;
	logic [TBL_COUNT_W-1:0] entry_count;
	logic                   matched;
	logic                   recorded;
	logic                   table_full;
	int                     mismatches;
	int                     outstanding;

	// Idling controls and the stall stretch in progress.
	bit pace_on = 1;
	bit stall_on = 1;
	int stall_left = 0;

	// Ranges offered by qualifying adds, used to aim lookups.
	logic [31:0] seg_lo[$];
	logic [31:0] seg_len[$];

	code_range_table_lookup #(.TABLE_DEPTH(DEPTH)) dut (.*);

	code_range_table_lookup_checker #(.TABLE_DEPTH(DEPTH)) checker_i (.*);

	always #5 clk = ~clk;

	// Result side backpressure: mostly short stalls, a few long ones.
	always @(negedge clk) begin : stall_gen
		int r;
		r = $urandom_range(0, 99);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!stall_on || r < 70) begin
			out_stall <= 1'b0;
		end else if (r < 95) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(10, 50);
		end
	end

	// Watchdog: ends the run when no channel moves for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("code_range_table_lookup_tb NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!pace_on || r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Offers one item after a random gap and waits until it is taken.
	task automatic send_request(logic kind, logic ld, logic ex, logic [31:0] vaddr,
		logic [31:0] base, logic [31:0] size, logic [31:0] iaddr, logic [31:0] ibytes,
		logic last, logic [31:0] lookup_pc);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_type <= kind;
		is_loadable <= ld;
		is_executable <= ex;
		seg_vaddr <= vaddr;
		base_addr <= base;
		mem_size <= size;
		index_addr <= iaddr;
		index_bytes <= ibytes;
		last_header <= last;
		pc <= lookup_pc;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic add_header(logic ld, logic ex, logic [31:0] vaddr, logic [31:0] base,
		logic [31:0] size, logic [31:0] iaddr, logic [31:0] ibytes, logic last);
		if (iaddr != 0 && ld && ex) begin
			seg_lo.push_back(base + vaddr);
			seg_len.push_back(size);
		end
		send_request(REQ_ADD, ld, ex, vaddr, base, size, iaddr, ibytes, last, $urandom);
	endtask

	// Lookup with noise on the fields that only an add uses.
	task automatic lookup_pc(logic [31:0] target_pc);
		send_request(REQ_LOOKUP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom, $urandom, $urandom, $urandom, $urandom,
			1'($urandom_range(0, 1)), target_pc);
	endtask

	// Random program header: mostly qualifying, mostly small segments.
	task automatic random_header();
		logic [31:0] vaddr;
		logic [31:0] size;
		int          r;
		r = $urandom_range(0, 99);
		vaddr = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 'hFFFF);
		if (r < 70)
			size = $urandom_range(1, 4096);
		else if (r < 85)
			size = '0;
		else
			size = $urandom;
		add_header($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0, vaddr, $urandom,
			size, ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom, $urandom,
			1'($urandom_range(0, 1)));
	endtask

	// Random lookup aimed inside, at the edges of, or away from known ranges.
	task automatic random_lookup();
		int          r;
		int          k;
		logic [31:0] lo;
		logic [31:0] len;
		logic [31:0] target;
		r = $urandom_range(0, 99);
		target = $urandom;
		if (seg_lo.size() != 0 && r < 70) begin
			k = $urandom_range(0, seg_lo.size() - 1);
			lo = seg_lo[k];
			len = seg_len[k];
			if (r < 55) begin
				target = lo + ((len == 0) ? 32'h0 : $urandom_range(0, len - 1));
			end else begin
				case ($urandom_range(0, 3))
					0: target = lo;
					1: target = lo + len;
					2: target = lo + len - 1;
					default: target = lo - 1;
				endcase
			end
		end else if (r < 80) begin
			case ($urandom_range(0, 3))
				0: target = 32'h0;
				1: target = 32'hFFFF_FFFF;
				2: target = 32'h8000_0000;
				default: target = 32'h7FFF_FFFF;
			endcase
		end
		lookup_pc(target);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_fallback(logic [31:0] start_addr, logic [31:0] end_addr);
		write_reg(REG_DEF_START, start_addr);
		write_reg(REG_DEF_END, end_addr);
	endtask

	// Holds the sender until every outstanding result has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		int phase;
		int n;
		int add_pct;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Empty table with the reset fallback, then a real fallback.
		lookup_pc(32'h0);
		drain();
		set_fallback(32'h0000_1000, 32'h0000_1800);
		lookup_pc(32'h1234_5678);

		// Adds that do not qualify.
		add_header(1'b1, 1'b1, 32'h100, 32'h1000, 32'h40, 32'h0, 32'h80, 1'b0);
		add_header(1'b0, 1'b1, 32'h100, 32'h1000, 32'h40, 32'h5000, 32'h80, 1'b0);
		add_header(1'b1, 1'b0, 32'h100, 32'h1000, 32'h40, 32'h5000, 32'h80, 1'b1);

		// Start wraps to zero, largest entry count.
		add_header(1'b1, 1'b1, 32'h1, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1);
		// End wraps below start: never matches.
		add_header(1'b1, 1'b1, 32'h0, 32'hFFFF_FF00, 32'h200, 32'h1111, 32'h10, 1'b0);
		// Empty range.
		add_header(1'b1, 1'b1, 32'h0, 32'h4000, 32'h0, 32'h8000_0000, 32'h7, 1'b0);
		// Overlaps the first entry, which must win.
		add_header(1'b1, 1'b1, 32'h0, 32'h80, 32'h1000, 32'h2222, 32'h800, 1'b1);
		// Ends just below the top of the address space.
		add_header(1'b1, 1'b1, 32'h0, 32'hFFFF_F000, 32'hFFF, 32'h1, 32'h8, 1'b0);

		lookup_pc(32'h0);
		lookup_pc(32'hFF);
		lookup_pc(32'h80);
		lookup_pc(32'h100);
		lookup_pc(32'h1080);
		lookup_pc(32'hFFFF_FF80);
		lookup_pc(32'hFFFF_FFFF);
		lookup_pc(32'h4000);

		// Extreme fallback settings, then writes to undecoded indexes.
		drain();
		set_fallback(32'h0, 32'hFFFF_FFFF);
		lookup_pc(32'h1080);
		drain();
		set_fallback(32'hFFFF_FFFF, 32'h0);
		lookup_pc(32'h1080);
		drain();
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		lookup_pc(32'hFFFF_FFFF);

		// Random phases; the last one adds faster so that the table fills up.
		for (phase = 0; phase < 3; phase++) begin
			drain();
			case (phase)
				0: set_fallback($urandom, $urandom);
				1: begin
					set_fallback(32'hFFFF_FFFF, 32'hFFFF_FFFF);
					write_reg(REG_SPARE_A, $urandom);
				end
				default: begin
					set_fallback(32'h0, 32'h0);
					write_reg(REG_SPARE_B, $urandom);
					write_reg(REG_DEF_END, $urandom);
				end
			endcase
			add_pct = (phase == 2) ? 10 : 5;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 100 == 0) begin
					pace_on = !(phase == 0 && n == 0) && $urandom_range(0, 3) != 0;
					stall_on = !(phase == 0 && n == 0) && $urandom_range(0, 3) != 0;
				end
				if (n == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(0, 99) < add_pct)
					random_header();
				else
					random_lookup();
			end
		end

		drain();
		repeat (80) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("code_range_table_lookup_tb OK");
		else
			$display("code_range_table_lookup_tb NOT OK");
		$finish;
	end

endmodule

// File: code_range_table_lookup.f
hdl/crtl_pkg.sv
hdl/crtl_ram.sv
hdl/code_range_table_lookup.sv
tb/code_range_table_lookup_checker.sv
tb/code_range_table_lookup_tb.sv
